### src/flat_face_shade_unit_top_defines.svh
// Assertion macros used by the shading unit top module.
`ifndef FLAT_FACE_SHADE_UNIT_TOP_DEFINES_SVH
`define FLAT_FACE_SHADE_UNIT_TOP_DEFINES_SVH

// Check that a condition implies another in the same cycle.
`define FFSU_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check that a condition implies another in the following cycle.
`define FFSU_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### src/ffsu_pkg.sv
package ffsu_pkg;

   localparam int COORD_W    = 14;
   localparam int EDGE_W     = 15;
   localparam int PROD_W     = 30;
   localparam int NORM_W     = 31;
   localparam int SQ_W       = 60;
   localparam int SUM_W      = 62;
   localparam int SQ_SHIFT   = 12;
   localparam int ROOT_IN_W  = 32;
   localparam int ROOT_W     = 16;
   localparam int ROOT_REM_W = 20;
   localparam int RECIP_W    = 17;
   localparam int ROOT_STEPS = 16;
   localparam int DIV_STEPS  = 17;
   localparam int RECIP_LAT  = ROOT_STEPS + DIV_STEPS;
   localparam int IDX_W      = 11;
   localparam int SHADE_W    = 8;
   localparam int SCALE_W    = NORM_W + RECIP_W + 1;

   localparam int DEF_MAX_FACES = 2048;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;

   localparam logic [CSR_IDX_W-1:0] REG_NORMAL_SHIFT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SHADE_SHIFT  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SHADE_OFFSET = 2'd2;

   localparam logic [3:0]        RST_NORMAL_SHIFT = 4'd5;
   localparam logic [4:0]        RST_SHADE_SHIFT  = 5'd15;
   localparam logic signed [7:0] RST_SHADE_OFFSET = -8'sd70;

   localparam logic [SHADE_W-1:0] SHADE_BASE = 8'd192;
   localparam int                 SHADE_MAX  = 63;
   localparam logic [RECIP_W-1:0] RECIP_ONE  = 17'd65536;

   // Face bookkeeping that rides along the pipeline
   typedef struct packed {
      logic                     valid;
      logic                     comp;
      logic [IDX_W-1:0]         idx;
      logic signed [NORM_W-1:0] nz;
   } meta_type;

endpackage

### src/flat_face_shade_unit_top.sv
// Flat shading unit: takes one triangle face per cycle while req_stall is low and returns
// one palette shade word per face; the word is registered at the output and is held while
// rsp_stall is high. Faces with the compute flag get a fresh reciprocal normal length
// from a 16-stage square root and a 17-stage divider, stored in a one-port-write,
// one-port-read table of MAX_FACES entries; other faces read their stored value. A face that
// reads an entry written by the face directly ahead is served by forwarding. The pipeline
// only halts when the output word is held and the stage behind it is full. Reading an entry
// that was never written returns undefined data. The user must write configuration through
// the csr port only while the unit is idle; the block itself does not enforce this.
module flat_face_shade_unit_top
   import ffsu_pkg::*;
#(
   parameter int MAX_FACES = DEF_MAX_FACES
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [IDX_W-1:0]            req_face_index,
   input  logic                        req_compute_norm,
   input  logic signed [COORD_W-1:0]   req_ax,
   input  logic signed [COORD_W-1:0]   req_ay,
   input  logic signed [COORD_W-1:0]   req_az,
   input  logic signed [COORD_W-1:0]   req_bx,
   input  logic signed [COORD_W-1:0]   req_by,
   input  logic signed [COORD_W-1:0]   req_bz,
   input  logic signed [COORD_W-1:0]   req_cx,
   input  logic signed [COORD_W-1:0]   req_cy,
   input  logic signed [COORD_W-1:0]   req_cz,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [SHADE_W-1:0]          rsp_shade_color,
   output logic [RECIP_W-1:0]          rsp_recip_length,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [CSR_DATA_W-1:0]       csr_wdata
);

`include "flat_face_shade_unit_top_defines.svh"

   localparam int AW = (MAX_FACES > 1) ? $clog2(MAX_FACES) : 1;

   logic en;
   logic accept;

   // Configuration registers
   logic [3:0]        normal_shift_ff;
   logic [4:0]        shade_shift_ff;
   logic signed [7:0] shade_offset_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         normal_shift_ff <= RST_NORMAL_SHIFT;
         shade_shift_ff  <= RST_SHADE_SHIFT;
         shade_offset_ff <= RST_SHADE_OFFSET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_NORMAL_SHIFT: normal_shift_ff <= csr_wdata[3:0];
            REG_SHADE_SHIFT:  shade_shift_ff  <= csr_wdata[4:0];
            REG_SHADE_OFFSET: shade_offset_ff <= $signed(csr_wdata);
            default: ;
         endcase
      end
   end

   // Stage 1: edges
   logic                     s1_valid_ff, s1_comp_ff;
   logic [IDX_W-1:0]         s1_idx_ff;
   logic signed [EDGE_W-1:0] dx1_ff, dy1_ff, dz1_ff, dx2_ff, dy2_ff, dz2_ff;

   // Stage 2: edge products
   logic                     s2_valid_ff, s2_comp_ff;
   logic [IDX_W-1:0]         s2_idx_ff;
   logic signed [PROD_W-1:0] px1_ff, px2_ff, py1_ff, py2_ff, pz1_ff, pz2_ff;

   // Stage 3: shifted normal
   meta_type                 s3_ff;
   logic signed [NORM_W-1:0] nx_ff, ny_ff;

   // Stage 4: squares
   meta_type                 s4_ff;
   logic [SQ_W-1:0]          sqx_ff, sqy_ff, sqz_ff;

   // Stage 5: root operand
   meta_type                 s5_ff;
   logic [ROOT_IN_W-1:0]     rop_ff;

   // Combinational values between stages
   logic signed [NORM_W-1:0]   cx_in, cy_in, cz_in;
   logic signed [2*NORM_W-1:0] mx_in, my_in, mz_in;
   logic [SUM_W-1:0]           sum_in;
   logic [SUM_W-SQ_SHIFT-1:0]  sumsh_in;
   logic [ROOT_IN_W-1:0]       rop_in;

   assign accept = req_valid && !req_stall;

   always_comb begin
      cx_in = (NORM_W'(py2_ff) - NORM_W'(py1_ff)) >>> normal_shift_ff;
      cy_in = (NORM_W'(px1_ff) - NORM_W'(px2_ff)) >>> normal_shift_ff;
      cz_in = (NORM_W'(pz1_ff) - NORM_W'(pz2_ff)) >>> normal_shift_ff;
      mx_in = nx_ff * nx_ff;
      my_in = ny_ff * ny_ff;
      mz_in = s3_ff.nz * s3_ff.nz;
      sum_in   = SUM_W'(sqx_ff) + SUM_W'(sqy_ff) + SUM_W'(sqz_ff);
      sumsh_in = sum_in[SUM_W-1:SQ_SHIFT];
      // Floor at one, saturate to 32 bits
      if (sumsh_in == '0) begin
         rop_in = ROOT_IN_W'(1);
      end else if (sumsh_in[SUM_W-SQ_SHIFT-1:ROOT_IN_W] != '0) begin
         rop_in = '1;
      end else begin
         rop_in = sumsh_in[ROOT_IN_W-1:0];
      end
   end

   // Front pipeline: clear valid bits on reset, advance valid and payload together
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff    <= 1'b0;
         s2_valid_ff    <= 1'b0;
         s3_ff.valid    <= 1'b0;
         s4_ff.valid    <= 1'b0;
         s5_ff.valid    <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= accept;
         s2_valid_ff <= s1_valid_ff;
         s3_ff.valid <= s2_valid_ff;
         s4_ff.valid <= s3_ff.valid;
         s5_ff.valid <= s4_ff.valid;

         s1_comp_ff <= req_compute_norm;
         s1_idx_ff  <= req_face_index;
         dx1_ff     <= EDGE_W'(req_bx) - EDGE_W'(req_ax);
         dy1_ff     <= EDGE_W'(req_by) - EDGE_W'(req_ay);
         dz1_ff     <= EDGE_W'(req_bz) - EDGE_W'(req_az);
         dx2_ff     <= EDGE_W'(req_cx) - EDGE_W'(req_ax);
         dy2_ff     <= EDGE_W'(req_cy) - EDGE_W'(req_ay);
         dz2_ff     <= EDGE_W'(req_cz) - EDGE_W'(req_az);

         s2_comp_ff <= s1_comp_ff;
         s2_idx_ff  <= s1_idx_ff;
         py1_ff     <= dy1_ff * dz2_ff;
         py2_ff     <= dy2_ff * dz1_ff;
         px1_ff     <= dx1_ff * dz2_ff;
         px2_ff     <= dx2_ff * dz1_ff;
         pz1_ff     <= dx2_ff * dy1_ff;
         pz2_ff     <= dx1_ff * dy2_ff;

         s3_ff.comp <= s2_comp_ff;
         s3_ff.idx  <= s2_idx_ff;
         s3_ff.nz   <= cz_in;
         nx_ff      <= cx_in;
         ny_ff      <= cy_in;

         s4_ff.comp <= s3_ff.comp;
         s4_ff.idx  <= s3_ff.idx;
         s4_ff.nz   <= s3_ff.nz;
         sqx_ff     <= SQ_W'(mx_in);
         sqy_ff     <= SQ_W'(my_in);
         sqz_ff     <= SQ_W'(mz_in);

         s5_ff.comp <= s4_ff.comp;
         s5_ff.idx  <= s4_ff.idx;
         s5_ff.nz   <= s4_ff.nz;
         rop_ff     <= rop_in;
      end
   end

   // Reciprocal length pipeline
   logic [RECIP_W-1:0] recip_out;

   ffsu_recip u_recip (
      .clock     (clock),
      .en        (en),
      .root_in   (rop_ff),
      .recip_out (recip_out)
   );

   // Carry the face alongside the root and divider stages
   meta_type md_ff [RECIP_LAT];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < RECIP_LAT; i++) begin
            md_ff[i].valid <= 1'b0;
         end
      end else if (en) begin
         md_ff[0] <= s5_ff;
         for (int i = 1; i < RECIP_LAT; i++) begin
            md_ff[i] <= md_ff[i-1];
         end
      end
   end

   // Reciprocal table: read one stage ahead, write at the write-back stage
   meta_type           w_m, r_m;
   logic               w_in_range, r_in_range, w_write;
   logic [RECIP_W-1:0] recip_mem [MAX_FACES];
   logic [RECIP_W-1:0] rd_ff;
   logic               fwd_ff;
   logic [RECIP_W-1:0] fwd_data_ff;
   logic [RECIP_W-1:0] recip_sel;

   assign w_m        = md_ff[RECIP_LAT-1];
   assign r_m        = md_ff[RECIP_LAT-2];
   assign w_in_range = 32'(w_m.idx) < 32'(MAX_FACES);
   assign r_in_range = 32'(r_m.idx) < 32'(MAX_FACES);
   assign w_write    = w_m.valid && w_m.comp && w_in_range;

   always_ff @(posedge clock) begin
      if (en) begin
         if (w_write) begin
            recip_mem[AW'(w_m.idx)] <= recip_out;
         end
         rd_ff <= recip_mem[AW'(r_m.idx)];
      end
   end

   // Forward a value written in the same cycle as the read
   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff <= 1'b0;
      end else if (en) begin
         fwd_ff <= w_write && r_in_range && (w_m.idx == r_m.idx);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         fwd_data_ff <= recip_out;
      end
   end

   always_comb begin
      priority if (w_m.comp) begin
         recip_sel = recip_out;
      end else if (!w_in_range) begin
         recip_sel = '0;
      end else if (fwd_ff) begin
         recip_sel = fwd_data_ff;
      end else begin
         recip_sel = rd_ff;
      end
   end

   // Scale stage: normal z times reciprocal length
   logic                      p_valid_ff;
   logic signed [SCALE_W-1:0] p_prod_ff;
   logic [RECIP_W-1:0]        p_recip_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
      end else if (en) begin
         p_valid_ff <= w_m.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p_prod_ff  <= SCALE_W'(w_m.nz) * $signed({1'b0, recip_sel});
         p_recip_ff <= recip_sel;
      end
   end

   // Shift, bias and clamp into the palette range
   logic signed [SCALE_W-1:0] shd_sum;
   logic [SHADE_W-1:0]        shade_in;

   always_comb begin
      shd_sum = (p_prod_ff >>> shade_shift_ff) + SCALE_W'(shade_offset_ff);
      if (shd_sum < 0) begin
         shade_in = SHADE_BASE;
      end else if (shd_sum > SCALE_W'(SHADE_MAX)) begin
         shade_in = SHADE_BASE + SHADE_W'(SHADE_MAX);
      end else begin
         shade_in = SHADE_BASE + shd_sum[SHADE_W-1:0];
      end
   end

   // Output word register
   logic               rsp_valid_ff;
   logic [SHADE_W-1:0] rsp_shade_ff;
   logic [RECIP_W-1:0] rsp_recip_ff;
   logic               out_load;
   logic               halt;

   assign out_load = !rsp_valid_ff || !rsp_stall;

   // Halt only when the held word would be overrun
   assign halt      = rsp_valid_ff && rsp_stall && p_valid_ff;
   assign en        = !halt;
   assign req_stall = !en;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= p_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_shade_ff <= shade_in;
         rsp_recip_ff <= p_recip_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_shade_color  = rsp_shade_ff;
   assign rsp_recip_length = rsp_recip_ff;

   `FFSU_ASSERT_SAME(a_no_overrun, halt, req_stall && !out_load,
                     "scale stage would overrun the held word")
   `FFSU_ASSERT_NEXT(a_scale_holds, halt,
                     p_valid_ff && $stable(p_prod_ff) && $stable(p_recip_ff),
                     "scale stage changed while halted")
   `FFSU_ASSERT_SAME(a_recip_range, w_m.valid && w_m.comp,
                     recip_out != '0 && recip_out <= RECIP_ONE,
                     "computed reciprocal length out of range")

endmodule

### src/ffsu_recip.sv
module ffsu_recip
   import ffsu_pkg::*;
(
   input  logic                 clock,
   input  logic                 en,
   input  logic [ROOT_IN_W-1:0] root_in,
   output logic [RECIP_W-1:0]   recip_out
);

   // Square root: two input bits per stage
   logic [ROOT_IN_W-1:0]  op_ff    [ROOT_STEPS];
   logic [ROOT_REM_W-1:0] rrem_ff  [ROOT_STEPS];
   logic [ROOT_W-1:0]     root_ff  [ROOT_STEPS];
   logic [ROOT_IN_W-1:0]  op_in    [ROOT_STEPS];
   logic [ROOT_REM_W-1:0] rrem_in  [ROOT_STEPS];
   logic [ROOT_W-1:0]     root_in_s [ROOT_STEPS];

   // Division of 65536 by the root: one quotient bit per stage
   logic [ROOT_W-1:0]  dvs_ff [DIV_STEPS];
   logic [ROOT_W-1:0]  drem_ff [DIV_STEPS];
   logic [RECIP_W-1:0] quo_ff [DIV_STEPS];
   logic [ROOT_W-1:0]  dvs_in [DIV_STEPS];
   logic [ROOT_W-1:0]  drem_in [DIV_STEPS];
   logic [RECIP_W-1:0] quo_in [DIV_STEPS];

   genvar k;
   generate
      for (k = 0; k < ROOT_STEPS; k++) begin : g_root
         logic [ROOT_IN_W-1:0]  op_src;
         logic [ROOT_REM_W-1:0] rem_src;
         logic [ROOT_W-1:0]     rt_src;

         if (k == 0) begin : g_head
            assign op_src  = root_in;
            assign rem_src = '0;
            assign rt_src  = '0;
         end else begin : g_tail
            assign op_src  = op_ff[k-1];
            assign rem_src = rrem_ff[k-1];
            assign rt_src  = root_ff[k-1];
         end

         always_comb begin
            logic [ROOT_REM_W-1:0] rem_sh;
            logic [ROOT_REM_W-1:0] trial;
            rem_sh = {rem_src[ROOT_REM_W-3:0], op_src[ROOT_IN_W-1 -: 2]};
            trial  = ROOT_REM_W'({rt_src, 2'b01});
            op_in[k] = {op_src[ROOT_IN_W-3:0], 2'b00};
            if (rem_sh >= trial) begin
               rrem_in[k]   = rem_sh - trial;
               root_in_s[k] = {rt_src[ROOT_W-2:0], 1'b1};
            end else begin
               rrem_in[k]   = rem_sh;
               root_in_s[k] = {rt_src[ROOT_W-2:0], 1'b0};
            end
         end

         always_ff @(posedge clock) begin
            if (en) begin
               op_ff[k]   <= op_in[k];
               rrem_ff[k] <= rrem_in[k];
               root_ff[k] <= root_in_s[k];
            end
         end
      end

      for (k = 0; k < DIV_STEPS; k++) begin : g_div
         logic [ROOT_W-1:0]  dvs_src;
         logic [ROOT_W-1:0]  rem_src;
         logic [RECIP_W-1:0] q_src;

         if (k == 0) begin : g_head
            // Floor the root at one
            assign dvs_src = (root_ff[ROOT_STEPS-1] == '0) ? ROOT_W'(1)
                                                          : root_ff[ROOT_STEPS-1];
            assign rem_src = '0;
            assign q_src   = '0;
         end else begin : g_tail
            assign dvs_src = dvs_ff[k-1];
            assign rem_src = drem_ff[k-1];
            assign q_src   = quo_ff[k-1];
         end

         always_comb begin
            logic [ROOT_W:0] rem2;
            // Dividend is 65536: only its top bit is set
            rem2 = {rem_src, 1'(k == 0)};
            dvs_in[k] = dvs_src;
            if (rem2 >= {1'b0, dvs_src}) begin
               drem_in[k] = ROOT_W'(rem2 - {1'b0, dvs_src});
               quo_in[k]  = {q_src[RECIP_W-2:0], 1'b1};
            end else begin
               drem_in[k] = rem2[ROOT_W-1:0];
               quo_in[k]  = {q_src[RECIP_W-2:0], 1'b0};
            end
         end

         always_ff @(posedge clock) begin
            if (en) begin
               dvs_ff[k]  <= dvs_in[k];
               drem_ff[k] <= drem_in[k];
               quo_ff[k]  <= quo_in[k];
            end
         end
      end
   endgenerate

   assign recip_out = quo_ff[DIV_STEPS-1];

endmodule
